/* rtl/hbp_pkg.sv */
// hbp_pkg: shared types, codes and constants for the prefix-code bit packer
// used by every module under rtl/ except hbp_fifo, depends on nothing
package hbp_pkg;

  // fixed field widths
  localparam int WORD_W = 32;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;
  localparam int PAD_W  = 4;
  localparam int ACC_W  = 7;
  localparam int CNT_W  = 3;

  // parameter defaults and queue depths
  localparam int DEF_MAX_CODE_LEN = 32;
  localparam int DEF_SYMBOL_COUNT = 256;
  localparam int CMD_DEPTH        = 2;
  localparam int RES_DEPTH        = 4;

  // input request kinds
  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DATA    = 2'd0,
    ST_FINAL   = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  // classified commands for the packing back end
  typedef enum logic [1:0] {
    OP_ENCODE  = 2'd0,
    OP_FLUSH   = 2'd1,
    OP_UNKNOWN = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [PAD_W-1:0]  pad;
    status_t           status;
    logic              last;
  } res_t;

endpackage

/* rtl/hbp_fifo.sv */
// hbp_fifo: small register queue, one write and one head read per cycle
// depends on nothing; used for the command queue and the result queue
module hbp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CntW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* rtl/hbp_front.sv */
// hbp_front: accepts requests, owns the code table, classifies each encode or
// flush request into a command for the back end; depends on hbp_pkg
module hbp_front #(
  parameter int MAX_CODE_LEN = hbp_pkg::DEF_MAX_CODE_LEN,
  parameter int SYMBOL_COUNT = hbp_pkg::DEF_SYMBOL_COUNT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  in_kind,
  input  logic [7:0]                  in_symbol,
  input  logic [hbp_pkg::WORD_W-1:0]  in_code_word,
  input  logic [hbp_pkg::LEN_W-1:0]   in_code_length,
  output logic                        cmd_push,
  output hbp_pkg::cmd_t               cmd_data,
  input  logic                        cmd_full
);
  import hbp_pkg::*;

  localparam int IdxW   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int CapLen = (MAX_CODE_LEN < WORD_W) ? MAX_CODE_LEN : WORD_W;
  localparam logic [LEN_W-1:0] CapLenV = LEN_W'(CapLen);

  logic [WORD_W-1:0] mem_code [SYMBOL_COUNT];
  logic [LEN_W-1:0]  mem_len  [SYMBOL_COUNT];
  logic              valid_r  [SYMBOL_COUNT];

  logic              accept, in_range, hit;
  logic [IdxW-1:0]   idx;
  logic [LEN_W-1:0]  len_cap;
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_flush_r, s1_hit_r;
  logic [WORD_W-1:0] rd_code_r;
  logic [LEN_W-1:0]  rd_len_r;

  // input decode
  assign full     = s1_valid_r && cmd_full;
  assign accept   = push && !full;
  assign in_range = ({1'b0, in_symbol} < 9'(SYMBOL_COUNT));
  assign idx      = in_symbol[IdxW-1:0];
  assign hit      = in_range && valid_r[idx];
  assign len_cap  = (in_code_length > CapLenV) ? CapLenV : in_code_length;

  // table write on load, registered read on encode
  always_ff @(posedge clk) begin
    if (accept && in_kind == KIND_LOAD && in_range) begin
      mem_code[idx] <= in_code_word;
      mem_len[idx]  <= len_cap;
    end
    if (accept && in_kind == KIND_ENCODE) begin
      rd_code_r <= mem_code[idx];
      rd_len_r  <= mem_len[idx];
    end
  end

  // entry valid bits
  always_ff @(posedge clk) begin
    for (int i = 0; i < SYMBOL_COUNT; i++) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (accept && in_kind == KIND_LOAD && in_range && idx == IdxW'(i)) begin
        valid_r[i] <= 1'b1;
      end
    end
  end

  // classify stage: only encode and flush move on
  assign cmd_push = s1_valid_r && !cmd_full;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (cmd_push) begin
      s1_valid_nxt = 1'b0;
    end
    if (accept && (in_kind == KIND_ENCODE || in_kind == KIND_FLUSH)) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flush_r <= (in_kind == KIND_FLUSH);
      s1_hit_r   <= hit;
    end
  end

  // command build
  always_comb begin
    cmd_data.word = rd_code_r;
    cmd_data.len  = rd_len_r;
    if (s1_flush_r) begin
      cmd_data.op = OP_FLUSH;
    end else if (s1_hit_r) begin
      cmd_data.op = OP_ENCODE;
    end else begin
      cmd_data.op = OP_UNKNOWN;
    end
  end

endmodule

/* rtl/hbp_back.sv */
// hbp_back: bit accumulator and byte packer, at most one result per cycle while
// res_full is low; depends on hbp_pkg; fed by the command queue, feeds the result queue
module hbp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_empty,
  input  hbp_pkg::cmd_t cmd_data,
  output logic          cmd_pop,
  output logic          res_push,
  output hbp_pkg::res_t res_data,
  input  logic          res_full
);
  import hbp_pkg::*;

  logic              work_valid_r, work_valid_nxt;
  op_t               op_r, op_nxt;
  logic [WORD_W-1:0] w_r, w_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic [3:0]        need;
  logic              emit, aft_fin, finish;
  logic [14:0]       acc_sh, acc_psh;
  logic [7:0]        top, enc_byte;
  logic [WORD_W-1:0] w_aft;
  logic [LEN_W-1:0]  rem_aft;
  logic [ACC_W-1:0]  acc_aft, acc_part;
  logic [CNT_W-1:0]  cnt_part;

  // byte assembly from pending bits and the head of the code
  assign top      = w_r[WORD_W-1 -: 8];
  assign need     = 4'd8 - {1'b0, cnt_r};
  assign emit     = (rem_r >= {2'b00, need});
  assign acc_sh   = {8'b0, acc_r} << need;
  assign enc_byte = acc_sh[7:0] | (top >> cnt_r);
  assign w_aft    = w_r << need;
  assign rem_aft  = rem_r - {2'b00, need};
  assign aft_fin  = (rem_aft < LEN_W'(8));
  assign acc_aft  = ACC_W'(w_aft[WORD_W-1 -: 8] >> (4'd8 - {1'b0, rem_aft[2:0]}));

  // leftover bits that do not complete a byte
  assign acc_psh  = {8'b0, acc_r} << rem_r[2:0];
  assign acc_part = acc_psh[ACC_W-1:0] | ACC_W'(top >> (4'd8 - {1'b0, rem_r[2:0]}));
  assign cnt_part = cnt_r + rem_r[2:0];

  // one step of the current command
  always_comb begin
    res_push       = 1'b0;
    res_data       = '0;
    finish         = 1'b0;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    w_nxt          = w_r;
    rem_nxt        = rem_r;
    op_nxt         = op_r;
    work_valid_nxt = work_valid_r;
    if (work_valid_r && !res_full) begin
      case (op_r)
        OP_ENCODE: begin
          if (emit) begin
            res_push        = 1'b1;
            res_data.data   = enc_byte;
            res_data.status = ST_DATA;
            res_data.last   = aft_fin;
            if (aft_fin) begin
              finish  = 1'b1;
              acc_nxt = acc_aft;
              cnt_nxt = rem_aft[2:0];
            end else begin
              w_nxt   = w_aft;
              rem_nxt = rem_aft;
              acc_nxt = '0;
              cnt_nxt = '0;
            end
          end else begin
            finish  = 1'b1;
            acc_nxt = acc_part;
            cnt_nxt = cnt_part;
          end
        end
        OP_FLUSH: begin
          res_push        = 1'b1;
          res_data.data   = acc_sh[7:0];
          res_data.pad    = need;
          res_data.status = ST_FINAL;
          res_data.last   = 1'b1;
          finish          = 1'b1;
          acc_nxt         = '0;
          cnt_nxt         = '0;
        end
        default: begin
          res_push        = 1'b1;
          res_data.status = ST_UNKNOWN;
          res_data.last   = 1'b1;
          finish          = 1'b1;
        end
      endcase
    end
    // take the next command when idle or as the current one ends
    cmd_pop = (!work_valid_r || finish) && !cmd_empty;
    if (cmd_pop) begin
      work_valid_nxt = 1'b1;
      op_nxt         = cmd_data.op;
      w_nxt          = cmd_data.word << (LEN_W'(WORD_W) - cmd_data.len);
      rem_nxt        = cmd_data.len;
    end else if (finish) begin
      work_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
      acc_r        <= '0;
      cnt_r        <= '0;
    end else begin
      work_valid_r <= work_valid_nxt;
      acc_r        <= acc_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    w_r   <= w_nxt;
    rem_r <= rem_nxt;
  end

endmodule

/* rtl/huffman_bit_packer_top.sv */
// path: an accepted encode or flush request passes the classify register,
// the command queue, the packer work registers and the result queue to the
// out ports; a flush or an unknown symbol yields a single result. throughput:
// one request per cycle in while full is low, at most one packed byte per
// cycle while res_full is low. reset: synchronous, clears entry valid bits,
// queues and the accumulator; the code table itself holds no reset value
module huffman_bit_packer_top #(
  parameter int MAX_CODE_LEN = hbp_pkg::DEF_MAX_CODE_LEN,
  parameter int SYMBOL_COUNT = hbp_pkg::DEF_SYMBOL_COUNT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 in_kind,
  input  logic [7:0]                 in_symbol,
  input  logic [hbp_pkg::WORD_W-1:0] in_code_word,
  input  logic [hbp_pkg::LEN_W-1:0]  in_code_length,
  output logic                       empty,
  input  logic                       pop,
  output logic [hbp_pkg::BYTE_W-1:0] out_byte,
  output logic [hbp_pkg::PAD_W-1:0]  out_pad_count,
  output logic [1:0]                 out_status,
  output logic                       out_last
);
  import hbp_pkg::*;

  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t cmd_in, cmd_out;
  logic res_push, res_full;
  res_t res_in, res_out;

  // request intake and table lookup
  hbp_front #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_kind       (in_kind),
    .in_symbol     (in_symbol),
    .in_code_word  (in_code_word),
    .in_code_length(in_code_length),
    .cmd_push      (cmd_push),
    .cmd_data      (cmd_in),
    .cmd_full      (cmd_full)
  );

  // command queue between front and packer
  hbp_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (cmd_push),
    .wr_data(cmd_in),
    .full   (cmd_full),
    .pop    (cmd_pop),
    .rd_data(cmd_out),
    .empty  (cmd_empty)
  );

  // byte packer
  hbp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_empty(cmd_empty),
    .cmd_data (cmd_out),
    .cmd_pop  (cmd_pop),
    .res_push (res_push),
    .res_data (res_in),
    .res_full (res_full)
  );

  // result queue toward the consumer
  hbp_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (res_push),
    .wr_data(res_in),
    .full   (res_full),
    .pop    (pop),
    .rd_data(res_out),
    .empty  (empty)
  );

  assign out_byte      = res_out.data;
  assign out_pad_count = res_out.pad;
  assign out_status    = res_out.status;
  assign out_last      = res_out.last;

endmodule

/* rtl/hbp_checker.sv */
// hbp_checker: port-level checks on the result channel of the bit packer
// depends on hbp_pkg; bound to huffman_bit_packer_top at the end of this file
module hbp_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       empty,
  input logic                       pop,
  input logic [hbp_pkg::BYTE_W-1:0] out_byte,
  input logic [hbp_pkg::PAD_W-1:0]  out_pad_count,
  input logic [1:0]                 out_status,
  input logic                       out_last
);
  import hbp_pkg::*;

  // nothing waits right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_byte) && $stable(out_status))
    else $error("waiting result changed before pop");

  // unknown symbol result is a bare last marker
  a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_status == ST_UNKNOWN |-> out_last && out_byte == '0 && out_pad_count == '0)
    else $error("malformed unknown symbol result");

  // flushed byte closes the request and carries one to eight pad bits
  a_final: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_status == ST_FINAL |-> out_last && out_pad_count != '0
      && out_pad_count <= 4'd8)
    else $error("malformed flush result");

  // data bytes never carry padding
  a_data: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_status == ST_DATA |-> out_pad_count == '0)
    else $error("padding on a data byte");

endmodule

bind huffman_bit_packer_top hbp_checker u_hbp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .empty        (empty),
  .pop          (pop),
  .out_byte     (out_byte),
  .out_pad_count(out_pad_count),
  .out_status   (out_status),
  .out_last     (out_last)
);
